@@ rtl/core/wes_pkg.sv @@
// ----------------------------------------------------------------------------
// wes_pkg
// shared constants, register codes and request types of the 3d wave stencil
// ----------------------------------------------------------------------------
package wes_pkg;

    // grid geometry
    localparam int MAX_GRID    = 64;
    localparam int MIN_GRID    = 3;
    localparam int POS_W       = $clog2(MAX_GRID);
    localparam int GRID_W      = POS_W + 1;
    localparam int ADDR_W      = 2 * POS_W;
    localparam int PLANE_WORDS = MAX_GRID * MAX_GRID;

    // arithmetic widths
    localparam int VALUE_BITS = 32;
    localparam int COEF_W     = 32;
    localparam int D_W        = VALUE_BITS + 2;      // second difference
    localparam int P_W        = D_W + COEF_W + 1;    // signed coefficient product
    localparam int T_W        = P_W - COEF_W;        // product after the q0.32 shift
    localparam int S_W        = T_W + 2;             // sum of three terms and the base

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Z    = 2'd3;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(50);
    localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(107374);

    // result queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] u_prev;
        logic signed [VALUE_BITS-1:0] u_prev2;
        logic                         frame_start;
    } point_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] u_next;
        logic                         last;
    } result_t;

endpackage

@@ rtl/core/wes_ram.sv @@
// ----------------------------------------------------------------------------
// wes_ram
// generic single-write, dual-read ram with registered read data
// ----------------------------------------------------------------------------
module wes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // reads return the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

@@ rtl/core/wave_equation_stencil_3d.sv @@
// ----------------------------------------------------------------------------
// wave_equation_stencil_3d
// one explicit time step of the 3d wave equation, 7-point stencil over x-planes
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  pt      | in        | pt_valid/pt_stall  | u_prev, u_prev2, frame_start
//  res     | out       | res_valid/res_stall| u_next, last
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one point request per cycle unless pt_stall is high; while the last
//  plane streams in each point yields two results, so the single result
//  port limits intake there
//  reset clears positions, bank select, pipeline and queue; the plane
//  stores are not cleared and need no sweep
//  a 16-entry result queue with a reservation counter absorbs res_stall;
//  pt_stall rises once fewer than two queue slots are left unreserved
//
// ----------------------------------------------------------------------------
module wave_equation_stencil_3d (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pt_valid,
    output logic                                pt_stall,
    input  wes_pkg::point_t                     pt,
    output logic                                res_valid,
    input  logic                                res_stall,
    output wes_pkg::result_t                    res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wes_pkg::COEF_W-1:0]          cfg_data
);

    localparam int VB = wes_pkg::VALUE_BITS;
    localparam int PW = wes_pkg::POS_W;
    localparam int GW = wes_pkg::GRID_W;

    // flags that travel with a point down the pipeline
    typedef struct packed {
        logic has_main;   // point x-1 gets a result
        logic active;     // point x-1 is interior in x, stencil applies
        logic has_edge;   // boundary result for plane n-1 follows
        logic last;       // boundary result closes the time step
    } flags_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GW-1:0]              grid_size_reg;
    logic [wes_pkg::COEF_W-1:0] coef_x_reg;
    logic [wes_pkg::COEF_W-1:0] coef_y_reg;
    logic [wes_pkg::COEF_W-1:0] coef_z_reg;
    logic [wes_pkg::CNT_W-1:0]  used_reg;
    logic [wes_pkg::CNT_W-1:0]  used_next;

    // writes are only taken while no result is owed
    assign cfg_ready = (used_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= wes_pkg::GRID_RESET;
            coef_x_reg    <= wes_pkg::COEF_RESET;
            coef_y_reg    <= wes_pkg::COEF_RESET;
            coef_z_reg    <= wes_pkg::COEF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wes_pkg::REG_GRID_SIZE: grid_size_reg <= cfg_data[GW-1:0];
                wes_pkg::REG_COEF_X:    coef_x_reg    <= cfg_data;
                wes_pkg::REG_COEF_Y:    coef_y_reg    <= cfg_data;
                wes_pkg::REG_COEF_Z:    coef_z_reg    <= cfg_data;
                default:                grid_size_reg <= grid_size_reg;
            endcase
        end
    end

    // grid size in use, clamped to the supported range
    logic [GW-1:0] n_size;
    logic [GW-1:0] n_m1;

    always_comb
    begin
        if (grid_size_reg < GW'(wes_pkg::MIN_GRID))
        begin
            n_size = GW'(wes_pkg::MIN_GRID);
        end
        else if (grid_size_reg > GW'(wes_pkg::MAX_GRID))
        begin
            n_size = GW'(wes_pkg::MAX_GRID);
        end
        else
        begin
            n_size = grid_size_reg;
        end
    end

    assign n_m1 = n_size - GW'(1);

    // ------------------------------------------------------------------
    // stage 0: position tracking, store addressing, write of the new plane
    // ------------------------------------------------------------------
    logic          accept;
    logic [PW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [PW-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic          bank_reg;      // bank holding the plane being stenciled
    logic          bank_next;
    logic [PW-1:0] x_cur, y_cur, z_cur;
    logic [GW-1:0] x_ext, y_ext, z_ext;
    logic [GW-1:0] x_inc, y_inc, z_inc;
    logic          wrap_z, wrap_y;
    logic [PW-1:0] y_lo, y_hi, z_lo, z_hi;
    logic [wes_pkg::ADDR_W-1:0] a_idx, a_ym, a_yp, a_zm, a_zp;
    flags_t        f0;
    logic [1:0]    res_cnt0;

    assign pt_stall = (used_reg > wes_pkg::CNT_W'(wes_pkg::FIFO_DEPTH - 2));
    assign accept   = pt_valid && !pt_stall;

    // a frame start restarts the sweep at the origin
    assign x_cur = pt.frame_start ? '0 : pos_x_reg;
    assign y_cur = pt.frame_start ? '0 : pos_y_reg;
    assign z_cur = pt.frame_start ? '0 : pos_z_reg;
    assign x_ext = {1'b0, x_cur};
    assign y_ext = {1'b0, y_cur};
    assign z_ext = {1'b0, z_cur};

    // wrap-around neighbors in y and z
    assign y_lo = (y_cur == '0) ? n_m1[PW-1:0] : y_cur - PW'(1);
    assign y_hi = (y_ext >= n_m1) ? '0 : y_cur + PW'(1);
    assign z_lo = (z_cur == '0) ? n_m1[PW-1:0] : z_cur - PW'(1);
    assign z_hi = (z_ext >= n_m1) ? '0 : z_cur + PW'(1);

    assign a_idx = {y_cur, z_cur};
    assign a_ym  = {y_lo, z_cur};
    assign a_yp  = {y_hi, z_cur};
    assign a_zm  = {y_cur, z_lo};
    assign a_zp  = {y_cur, z_hi};

    // result classification, output lags the input by one plane
    assign f0.has_main = (x_cur != '0);
    assign f0.active   = (x_ext >= GW'(2)) && (x_ext < n_size);
    assign f0.has_edge = (x_ext >= n_m1);
    assign f0.last     = (y_ext >= n_m1) && (z_ext >= n_m1);
    assign res_cnt0    = {1'b0, f0.has_main} + {1'b0, f0.has_edge};

    // raster advance, z fastest; planes swap roles at the end of a plane
    assign z_inc  = z_ext + GW'(1);
    assign y_inc  = y_ext + GW'(1);
    assign x_inc  = x_ext + GW'(1);
    assign wrap_z = (z_inc >= n_size);
    assign wrap_y = wrap_z && (y_inc >= n_size);

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            pos_z_next = wrap_z ? '0 : z_inc[PW-1:0];
            pos_y_next = wrap_z ? (wrap_y ? '0 : y_inc[PW-1:0]) : y_cur;
            pos_x_next = wrap_y ? ((x_inc >= n_size) ? '0 : x_inc[PW-1:0]) : x_cur;
            bank_next  = bank_reg ^ wrap_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            bank_reg  <= bank_next;
        end
    end

    // ------------------------------------------------------------------
    // plane stores: two banks of u_prev, three copies each for read ports
    //   copy 0 also keeps u_prev2 next to u_prev (center read gets both)
    //   the bank not being stenciled takes the incoming plane; its old
    //   entry at the same address is the x-1 neighbor, read before write
    // ------------------------------------------------------------------
    logic [2*VB-1:0] c0a_data [2];
    logic [2*VB-1:0] c0b_data [2];
    logic [VB-1:0]   c1a_data [2];
    logic [VB-1:0]   c1b_data [2];
    logic [VB-1:0]   c2a_data [2];
    logic [VB-1:0]   c2b_data [2];
    logic [1:0]      bank_we;

    generate
        for (genvar b = 0; b < 2; b++)
        begin : g_bank
            assign bank_we[b] = accept && (bank_reg != 1'(b));

            wes_ram #(
                .WIDTH (2 * VB),
                .DEPTH (wes_pkg::PLANE_WORDS)
            ) u_copy0 (
                .clk     (clk),
                .we      (bank_we[b]),
                .waddr   (a_idx),
                .wdata   ({pt.u_prev2, pt.u_prev}),
                .raddr_a (a_idx),
                .rdata_a (c0a_data[b]),
                .raddr_b (a_ym),
                .rdata_b (c0b_data[b])
            );

            wes_ram #(
                .WIDTH (VB),
                .DEPTH (wes_pkg::PLANE_WORDS)
            ) u_copy1 (
                .clk     (clk),
                .we      (bank_we[b]),
                .waddr   (a_idx),
                .wdata   (pt.u_prev),
                .raddr_a (a_yp),
                .rdata_a (c1a_data[b]),
                .raddr_b (a_zm),
                .rdata_b (c1b_data[b])
            );

            wes_ram #(
                .WIDTH (VB),
                .DEPTH (wes_pkg::PLANE_WORDS)
            ) u_copy2 (
                .clk     (clk),
                .we      (bank_we[b]),
                .waddr   (a_idx),
                .wdata   (pt.u_prev),
                .raddr_a (a_zp),
                .rdata_a (c2a_data[b]),
                .raddr_b (a_idx),
                .rdata_b (c2b_data[b])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // stage 1: store data arrives, second differences per axis
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic                 s1_bank_reg;
    flags_t               s1_flags_reg;
    logic signed [VB-1:0] s1_u1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flags_reg <= '0;
            s1_bank_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_flags_reg <= f0;
            s1_bank_reg  <= bank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_u1_reg <= pt.u_prev;
    end

    logic [2*VB-1:0]              cen_word;
    logic signed [VB-1:0]         v_c, v_u2, v_xm, v_ym, v_yp, v_zm, v_zp;
    logic signed [wes_pkg::D_W-1:0] two_c;
    logic signed [wes_pkg::D_W-1:0] d_x, d_y, d_z, base1;

    assign cen_word = c0a_data[s1_bank_reg];
    assign v_c      = cen_word[VB-1:0];
    assign v_u2     = cen_word[2*VB-1:VB];
    assign v_ym     = c0b_data[s1_bank_reg][VB-1:0];
    assign v_yp     = c1a_data[s1_bank_reg];
    assign v_zm     = c1b_data[s1_bank_reg];
    assign v_zp     = c2a_data[s1_bank_reg];
    assign v_xm     = c2b_data[~s1_bank_reg];

    assign two_c = {v_c[VB-1], v_c, 1'b0};
    assign d_x   = {{2{v_xm[VB-1]}}, v_xm} + {{2{s1_u1_reg[VB-1]}}, s1_u1_reg} - two_c;
    assign d_y   = {{2{v_ym[VB-1]}}, v_ym} + {{2{v_yp[VB-1]}}, v_yp} - two_c;
    assign d_z   = {{2{v_zm[VB-1]}}, v_zm} + {{2{v_zp[VB-1]}}, v_zp} - two_c;
    // 2*u(n-1) - u(n-2)
    assign base1 = two_c - {{2{v_u2[VB-1]}}, v_u2};

    // ------------------------------------------------------------------
    // stage 2: coefficient products, one multiplier per axis
    // ------------------------------------------------------------------
    logic                           s2_valid_reg;
    flags_t                         s2_flags_reg;
    logic signed [wes_pkg::D_W-1:0] s2_dx_reg, s2_dy_reg, s2_dz_reg, s2_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_flags_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dx_reg   <= d_x;
        s2_dy_reg   <= d_y;
        s2_dz_reg   <= d_z;
        s2_base_reg <= base1;
    end

    logic signed [wes_pkg::P_W-1:0] prod_x, prod_y, prod_z;

    assign prod_x = s2_dx_reg * $signed({1'b0, coef_x_reg});
    assign prod_y = s2_dy_reg * $signed({1'b0, coef_y_reg});
    assign prod_z = s2_dz_reg * $signed({1'b0, coef_z_reg});

    // ------------------------------------------------------------------
    // stage 3: drop the fraction (floor) and sum the terms
    // ------------------------------------------------------------------
    logic                           s3_valid_reg;
    flags_t                         s3_flags_reg;
    logic signed [wes_pkg::T_W-1:0] s3_tx_reg, s3_ty_reg, s3_tz_reg;
    logic signed [wes_pkg::D_W-1:0] s3_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_flags_reg <= '0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_tx_reg   <= prod_x[wes_pkg::P_W-1:wes_pkg::COEF_W];
        s3_ty_reg   <= prod_y[wes_pkg::P_W-1:wes_pkg::COEF_W];
        s3_tz_reg   <= prod_z[wes_pkg::P_W-1:wes_pkg::COEF_W];
        s3_base_reg <= s2_base_reg;
    end

    logic signed [wes_pkg::S_W-1:0] sum3;

    assign sum3 = {{2{s3_tx_reg[wes_pkg::T_W-1]}}, s3_tx_reg}
                + {{2{s3_ty_reg[wes_pkg::T_W-1]}}, s3_ty_reg}
                + {{2{s3_tz_reg[wes_pkg::T_W-1]}}, s3_tz_reg}
                + {{(wes_pkg::S_W - wes_pkg::D_W){s3_base_reg[wes_pkg::D_W-1]}},
                   s3_base_reg};

    // ------------------------------------------------------------------
    // stage 4: saturate and push into the result queue
    // ------------------------------------------------------------------
    logic                           s4_valid_reg;
    flags_t                         s4_flags_reg;
    logic signed [wes_pkg::S_W-1:0] s4_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s4_flags_reg <= '0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
            s4_flags_reg <= s3_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sum_reg <= sum3;
    end

    logic [wes_pkg::S_W-VB:0] sum_hi;
    logic                     sum_fits;
    logic signed [VB-1:0]     sat_val;
    logic signed [VB-1:0]     main_val;

    // fits when every bit above the value's sign bit matches it
    assign sum_hi   = s4_sum_reg[wes_pkg::S_W-1:VB-1];
    assign sum_fits = (&sum_hi) || (~|sum_hi);
    assign sat_val  = sum_fits ? s4_sum_reg[VB-1:0]
                    : (s4_sum_reg[wes_pkg::S_W-1] ? {1'b1, {(VB-1){1'b0}}}
                                                  : {1'b0, {(VB-1){1'b1}}});
    // planes x=0 and x=n-1 stay zero
    assign main_val = s4_flags_reg.active ? sat_val : '0;

    // ------------------------------------------------------------------
    // result queue, up to two pushes per cycle (interior then boundary)
    // ------------------------------------------------------------------
    wes_pkg::result_t           fifo_reg [wes_pkg::FIFO_DEPTH];
    logic [wes_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wes_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wes_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        push_main, push_edge, pop;
    logic [1:0]                  push_cnt;

    assign push_main = s4_valid_reg && s4_flags_reg.has_main;
    assign push_edge = s4_valid_reg && s4_flags_reg.has_edge;
    assign push_cnt  = {1'b0, push_main} + {1'b0, push_edge};
    assign pop       = res_valid && !res_stall;

    assign res_valid = (count_reg != '0);
    assign res       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_main)
        begin
            fifo_reg[wr_ptr_reg] <= '{u_next: main_val, last: 1'b0};
        end
        if (push_edge)
        begin
            fifo_reg[wr_ptr_reg + wes_pkg::FIFO_AW'(push_main)] <=
                '{u_next: '0, last: s4_flags_reg.last};
        end
    end

    assign wr_ptr_next = wr_ptr_reg + wes_pkg::FIFO_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + wes_pkg::FIFO_AW'(pop);
    assign count_next  = count_reg + wes_pkg::CNT_W'(push_cnt) - wes_pkg::CNT_W'(pop);

    // reservation: results owed by points in flight plus those queued
    assign used_next = used_reg
                     + (accept ? wes_pkg::CNT_W'(res_cnt0) : '0)
                     - wes_pkg::CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
        end
    end

endmodule

@@ rtl/core/wes_checker.sv @@
// ----------------------------------------------------------------------------
// wes_checker
// port-level checks of the wave stencil, bound to the top level
// ----------------------------------------------------------------------------
module wes_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pt_stall,
    input logic             res_valid,
    input logic             res_stall,
    input wes_pkg::result_t res,
    input logic             cfg_ready
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result request changed");

    // configuration is only open while no result is owed
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !res_valid)
        else $error("config ready with a result pending");

    // the closing point lies on the fixed boundary plane
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> res.u_next == '0)
        else $error("last result not zero");

    // input back-pressure only comes from owed results
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pt_stall |-> !cfg_ready)
        else $error("point stall while idle");

endmodule

bind wave_equation_stencil_3d wes_checker u_wes_checker (.*);

@@ test/wave_equation_stencil_3d_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_equation_stencil_3d_test
// self-checking bench for the 3d wave equation stencil
//
// point requests stream in raster order under several register settings;
// a local model of the plane stores and the q0.32 update predicts every
// result request, which is checked field by field in arrival order. both
// channels idle and stall at random, registers change only while idle
// ----------------------------------------------------------------------------
module wave_equation_stencil_3d_test;

    import wes_pkg::*;

    localparam int ACC_W         = 80;     // wide enough for any exact sum
    localparam int QUIET_CYCLES  = 20;     // time for the pipeline to empty after the last result
    localparam int STALL_LIMIT   = 5000;   // cycles without any handshake
    localparam int RANDOM_POINTS = 1800;
    localparam int REPORT_MAX    = 10;
    localparam int BIG_PHASE     = 3;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum int {STEP_CLEAN, STEP_FREE_RUN, STEP_CUT, STEP_NOISE} step_kind_e;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // block ports, all inputs known from time zero
    logic                 pt_valid  = 1'b0;
    logic                 pt_stall;
    point_t               pt        = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    result_t              res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data  = '0;

    wave_equation_stencil_3d i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt        (pt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // stencil model: register copies, two banks of u(n-1) planes, one u(n-2)
    // plane and the raster position
    // ------------------------------------------------------------------------
    logic [GRID_W-1:0]            grid_q   = GRID_RESET;
    logic [COEF_W-1:0]            coef_x_q = COEF_RESET;
    logic [COEF_W-1:0]            coef_y_q = COEF_RESET;
    logic [COEF_W-1:0]            coef_z_q = COEF_RESET;
    logic signed [VALUE_BITS-1:0] prev_planes [2][PLANE_WORDS];
    logic signed [VALUE_BITS-1:0] prev2_plane [PLANE_WORDS];
    bit                           cur_bank = 1'b0;   // bank taking the incoming plane
    int unsigned                  at_x = 0;
    int unsigned                  at_y = 0;
    int unsigned                  at_z = 0;

    result_t expected_layer [$];     // results still owed by the block
    point_t  point_requests [$];     // points not yet offered

    // run bookkeeping
    int unsigned points_taken  = 0;
    int unsigned results_seen  = 0;
    int unsigned error_count   = 0;
    int unsigned settings_used = 0;
    int unsigned largest_grid  = 0;
    int unsigned quiet_cycles  = 0;
    bit          pt_taken      = 1'b0;
    bit          pt_pace       = 1'b1;
    bit          res_pace      = 1'b1;
    int unsigned pt_wait       = 0;
    int unsigned stall_run     = 0;

    // grid size as the block uses it
    function automatic int unsigned effective_size(input logic [GRID_W-1:0] g);
        if (g < MIN_GRID)
            return MIN_GRID;
        if (g > MAX_GRID)
            return MAX_GRID;
        return g;
    endfunction

    // floor(c * (lo - 2 mid + hi) / 2^32), exact
    function automatic logic signed [ACC_W-1:0] axis_term(
        input logic signed [VALUE_BITS-1:0] lo_v,
        input logic signed [VALUE_BITS-1:0] mid_v,
        input logic signed [VALUE_BITS-1:0] hi_v,
        input logic [COEF_W-1:0]            c
    );
        logic signed [ACC_W-1:0] d;
        d = lo_v;
        d = d + hi_v - mid_v - mid_v;
        d = d * $signed({1'b0, c});
        return d >>> COEF_W;
    endfunction

    // advance the model by one accepted point and queue the results it owes
    function automatic void predict_new_layer(input point_t p);
        int unsigned             n;
        int unsigned             idx;
        int unsigned             ym;
        int unsigned             yp;
        int unsigned             zm;
        int unsigned             zp;
        logic signed [VALUE_BITS-1:0] ctr;
        logic signed [ACC_W-1:0] acc;
        result_t                 r;

        n = effective_size(grid_q);
        if (p.frame_start)
        begin
            at_x = 0;
            at_y = 0;
            at_z = 0;
        end
        idx = at_y * MAX_GRID + at_z;

        // the point one plane behind; boundary planes stay zero
        if (at_x >= 1)
        begin
            r = '0;
            if (at_x - 1 >= 1 && at_x - 1 < n - 1)
            begin
                ym  = (at_y == 0) ? n - 1 : at_y - 1;
                yp  = (at_y >= n - 1) ? 0 : at_y + 1;
                zm  = (at_z == 0) ? n - 1 : at_z - 1;
                zp  = (at_z >= n - 1) ? 0 : at_z + 1;
                ctr = prev_planes[!cur_bank][idx];
                acc = axis_term(prev_planes[cur_bank][idx], ctr, p.u_prev, coef_x_q)
                    + axis_term(prev_planes[!cur_bank][ym * MAX_GRID + at_z], ctr,
                                prev_planes[!cur_bank][yp * MAX_GRID + at_z], coef_y_q)
                    + axis_term(prev_planes[!cur_bank][at_y * MAX_GRID + zm], ctr,
                                prev_planes[!cur_bank][at_y * MAX_GRID + zp], coef_z_q)
                    + ctr + ctr - prev2_plane[idx];
                if (acc > VAL_MAX)
                    r.u_next = VAL_MAX;
                else if (acc < VAL_MIN)
                    r.u_next = VAL_MIN;
                else
                    r.u_next = acc[VALUE_BITS-1:0];
            end
            expected_layer.push_back(r);
        end

        // during the last plane the boundary point comes out as well
        if (at_x >= n - 1)
        begin
            r        = '0;
            r.last   = (at_y >= n - 1 && at_z >= n - 1);
            expected_layer.push_back(r);
        end

        prev_planes[cur_bank][idx] = p.u_prev;
        prev2_plane[idx]           = p.u_prev2;

        // raster advance, z fastest; a finished plane swaps the banks
        at_z++;
        if (at_z >= n)
        begin
            at_z = 0;
            at_y++;
            if (at_y >= n)
            begin
                at_y     = 0;
                cur_bank = !cur_bank;
                at_x++;
                if (at_x >= n)
                    at_x = 0;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_run();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] extreme_value(input int unsigned k);
        case (k % 4)
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // mostly values small enough to stay clear of saturation
    function automatic logic signed [VALUE_BITS-1:0] field_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return extreme_value($urandom_range(0, 3));
        if (r < 28)
            return $urandom;
        return $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
    endfunction

    function automatic logic [COEF_W-1:0] coef_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 30)
            return '1;
        if (r < 45)
            return COEF_RESET;
        if (r < 70)
            return $urandom;
        return $urandom_range(0, 32'h0FFF_FFFF);
    endfunction

    function automatic void queue_point(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b,
        input logic                         fs
    );
        point_t p;
        p.u_prev      = a;
        p.u_prev2     = b;
        p.frame_start = fs;
        point_requests.push_back(p);
    endfunction

    // one register write request; the model copy follows at the handshake
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COEF_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_GRID_SIZE: grid_q   = value[GRID_W-1:0];
            REG_COEF_X:    coef_x_q = value;
            REG_COEF_Y:    coef_y_q = value;
            REG_COEF_Z:    coef_z_q = value;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every point is taken and every result is back, then let
    // the pipeline empty out in case the last points owed nothing
    task automatic settle();
        while (point_requests.size() != 0 || pt_valid || expected_layer.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // point driver: accept at rising edges, offer at falling edges
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pt_valid && !pt_stall)
        begin
            predict_new_layer(pt);
            pt_taken = 1'b1;
            points_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pt_valid <= 1'b0;
        end
        else if (!pt_valid || pt_taken)
        begin
            pt_taken = 1'b0;
            if (pt_wait > 0)
            begin
                pt_wait--;
                pt_valid <= 1'b0;
            end
            else if (point_requests.size() != 0)
            begin
                pt       <= point_requests.pop_front();
                pt_valid <= 1'b1;
                pt_wait  = pt_pace ? idle_run() : 0;
            end
            else
            begin
                pt_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random back-pressure, in-order compare
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run--;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
            stall_run = res_pace ? idle_run() : 0;
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_layer.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("result %0d arrived with nothing owed: u_next %h last %b",
                             results_seen, res.u_next, res.last);
            end
            else
            begin
                want = expected_layer.pop_front();
                if (res.u_next !== want.u_next || res.last !== want.last)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display({"result %0d mismatch: expected u_next %h last %b, ",
                                  "got u_next %h last %b"}, results_seen,
                                 want.u_next, want.last, res.u_next, res.last);
                end
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((pt_valid && !pt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d results still owed",
                     STALL_LIMIT, expected_layer.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, directed step, random settings, large grid, end
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned n_eff;
        int unsigned last_n;
        int unsigned budget;
        int unsigned count;
        int unsigned len;
        int unsigned step_pts;
        int unsigned phase;
        int unsigned random_points;
        int unsigned r;
        step_kind_e  kind;
        logic        fs;
        bit          sync;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: size below range clamps to 3, coefficient extremes,
        // field extremes so both saturation limits and the last flag show up
        write_register(REG_GRID_SIZE, '0);
        write_register(REG_COEF_X, '1);
        write_register(REG_COEF_Y, '0);
        write_register(REG_COEF_Z, COEF_RESET);
        for (int i = 0; i < 27; i++)
            queue_point(extreme_value(i), extreme_value(i / 4 + i), i == 0);
        settle();
        settings_used = 1;
        last_n        = MIN_GRID;
        largest_grid  = MIN_GRID;
        phase         = 0;
        random_points = 0;

        while (random_points < RANDOM_POINTS || phase <= BIG_PHASE)
        begin
            pt_pace  = $urandom_range(0, 4) != 0;
            res_pace = $urandom_range(0, 4) != 0;

            if (phase == BIG_PHASE)
            begin
                // largest grid through an out-of-range size; three planes reach
                // the first interior plane including the wrap at index 63
                write_register(REG_GRID_SIZE, COEF_W'(127));
                write_register(REG_COEF_X, coef_value());
                write_register(REG_COEF_Y, coef_value());
                write_register(REG_COEF_Z, coef_value());
                n_eff = MAX_GRID;
                for (int j = 0; j < 3 * MAX_GRID * MAX_GRID; j++)
                    queue_point(field_value(), field_value(), j == 0);
            end
            else
            begin
                r = $urandom_range(0, 99);
                write_register(REG_GRID_SIZE, (r < 15) ? $urandom_range(0, 2)
                                                       : $urandom_range(3, 8));
                write_register(REG_COEF_X, coef_value());
                write_register(REG_COEF_Y, coef_value());
                write_register(REG_COEF_Z, coef_value());
                n_eff = effective_size(grid_q);

                // a larger grid must restart the step so no store entry is read
                // before the new size has written it; a smaller one may go on
                // from wherever the last setting stopped
                sync     = n_eff > last_n;
                step_pts = n_eff * n_eff * n_eff;
                budget   = $urandom_range(60, 250);
                count    = 0;
                while (count < budget)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        kind = STEP_CLEAN;
                    else if (r < 77)
                        kind = STEP_FREE_RUN;
                    else if (r < 89)
                        kind = STEP_CUT;
                    else
                        kind = STEP_NOISE;
                    len = (kind == STEP_CUT || kind == STEP_NOISE)
                        ? $urandom_range(1, step_pts - 1) : step_pts;
                    for (int j = 0; j < len; j++)
                    begin
                        if (kind == STEP_NOISE)
                            fs = $urandom_range(0, 7) == 0;
                        else
                            fs = (j == 0) && kind != STEP_FREE_RUN;
                        if (sync && count == 0 && j == 0)
                            fs = 1'b1;
                        queue_point(field_value(), field_value(), fs);
                    end
                    count += len;
                end
                // sometimes leave the step unfinished for the next setting
                if ($urandom_range(0, 9) < 3)
                begin
                    len = $urandom_range(1, step_pts - 1);
                    for (int j = 0; j < len; j++)
                        queue_point(field_value(), field_value(), j == 0);
                    count += len;
                end
                random_points += count;
            end

            settle();
            if (n_eff > largest_grid)
                largest_grid = n_eff;
            last_n = n_eff;
            settings_used++;
            phase++;
        end

        if (expected_layer.size() != 0)
        begin
            error_count += expected_layer.size();
            $display("%0d results never arrived", expected_layer.size());
        end
        $display("covered %0d point requests over %0d register settings, grid up to %0d",
                 points_taken, settings_used, largest_grid);
        $display("checked %0d result requests, %0d failures", results_seen, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ wave_equation_stencil_3d.f @@
rtl/core/wes_pkg.sv
rtl/core/wes_ram.sv
rtl/core/wave_equation_stencil_3d.sv
rtl/core/wes_checker.sv
test/wave_equation_stencil_3d_test.sv
